FILE: hw/rtl/msa_pkg.sv
// package for the minimal set absorber: command and state codes, result beat type
// and the count saturation helper; no dependencies
`default_nettype none

package msa_pkg;

	localparam int MAX_RESULTS = 32;
	localparam int NW          = $clog2(MAX_RESULTS);

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_DUMP  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_FINISH,
		ST_RESP,
		ST_DUMP_RD,
		ST_DUMP_WR
	} state_t;

	typedef struct packed {
		logic        is_sub;
		logic        is_sup;
	} cmp_res_t;

	typedef struct packed {
		logic        accepted;
		logic [5:0]  removed_count;
		logic        table_full;
		logic [5:0]  entry_count;
		logic        entry_valid;
		logic [31:0] entry_mask;
		logic        last;
	} res_t;

	function automatic logic [5:0] sat6(input logic [7:0] v);
		return (v > 8'd63) ? 6'd63 : v[5:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/msa_cmp.sv
// shared subset / superset compare between the new set and one stored slot
// depends on msa_pkg
`default_nettype none

module msa_cmp import msa_pkg::*; #(
	parameter int W = 32
) (
	input  wire logic [W-1:0] new_set,
	input  wire logic [W-1:0] slot_set,
	output cmp_res_t          rel
);

	always_comb begin
		rel.is_sub = ((slot_set & ~new_set) == '0);
		rel.is_sup = ((new_set & ~slot_set) == '0);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/msa_ctrl.sv
// sequencer for the minimal set absorber: slot memory, valid bits, slot scan,
// dump walk and result beat generation; depends on msa_pkg and msa_cmp
`default_nettype none

module msa_ctrl import msa_pkg::*; #(
	parameter int CAPACITY = 32,
	parameter int ELEMENTS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] set_mask,
	output logic             cmd_stall,
	input  wire logic        res_free,
	output logic             res_load,
	output res_t             res
);

	localparam int MW = (ELEMENTS < 32) ? ELEMENTS : 32;
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	state_t                state_q, state_d;
	logic [CAPACITY-1:0]   valid_q;
	logic [CW-1:0]         count_q;

	logic [MW-1:0]         mem [CAPACITY];
	logic [MW-1:0]         rdata_q;
	logic                  mem_re, mem_we;

	logic [MW-1:0]         s_q;
	logic [IW-1:0]         idx_q;
	logic                  rd_act_s1, rd_vld_s1;
	logic [IW-1:0]         rd_idx_s1;

	logic                  sub_found_q, free_found_q;
	logic [CAPACITY-1:0]   sup_bits_q;
	logic [CW-1:0]         removed_q;
	logic [IW-1:0]         free_idx_q;

	logic [CAPACITY-1:0]   rem_q;
	logic [NW-1:0]         n_q;

	logic [CAPACITY-1:0]   idx_onehot, free_onehot;
	logic                  dump_last, do_store;
	cmp_res_t              rel;
	logic                  hit_sub, hit_sup;

	msa_cmp #(.W(MW)) u_cmp (
		.new_set  (s_q),
		.slot_set (rdata_q),
		.rel      (rel)
	);

	assign idx_onehot  = {{(CAPACITY-1){1'b0}}, 1'b1} << idx_q;
	assign free_onehot = {{(CAPACITY-1){1'b0}}, 1'b1} << free_idx_q;
	assign dump_last   = ((rem_q & ~idx_onehot) == '0) || (n_q == NW'(MAX_RESULTS - 1));
	assign do_store    = !sub_found_q && free_found_q;
	assign hit_sub     = rd_vld_s1 && rel.is_sub;
	assign hit_sup     = rd_vld_s1 && rel.is_sup;
	assign cmd_stall   = (state_q != ST_IDLE);

	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		res      = '0;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd_t'(command))
						CMD_ADD:   state_d = ST_SCAN;
						CMD_CLEAR: state_d = ST_RESP;
						CMD_DUMP:  state_d = (valid_q == '0) ? ST_RESP : ST_DUMP_RD;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_SCAN: begin
				mem_re = 1'b1;
				if (idx_q == IW'(CAPACITY - 1))
					state_d = ST_TAIL;
			end
			ST_TAIL: state_d = ST_FINISH;
			ST_FINISH: begin
				if (res_free) begin
					res_load          = 1'b1;
					mem_we            = do_store;
					res.accepted      = do_store;
					res.table_full    = !sub_found_q && !free_found_q;
					res.removed_count = sub_found_q ? 6'd0 : sat6(8'(removed_q));
					res.entry_count   = do_store ? sat6(8'(count_q - removed_q + CW'(1)))
					                             : sat6(8'(count_q));
					res.last          = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_RESP: begin
				if (res_free) begin
					res_load        = 1'b1;
					res.entry_count = sat6(8'(count_q));
					res.last        = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_DUMP_RD: begin
				if (rem_q[idx_q]) begin
					mem_re  = 1'b1;
					state_d = ST_DUMP_WR;
				end
			end
			ST_DUMP_WR: begin
				if (res_free) begin
					res_load        = 1'b1;
					res.entry_count = sat6(8'(count_q));
					res.entry_valid = 1'b1;
					res.entry_mask  = 32'(rdata_q);
					res.last        = dump_last;
					state_d         = dump_last ? ST_IDLE : ST_DUMP_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			count_q   <= '0;
			rd_act_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_act_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_IDLE && cmd_valid && cmd_t'(command) == CMD_CLEAR) begin
				valid_q <= '0;
				count_q <= '0;
			end else if (mem_we) begin
				valid_q <= (valid_q & ~sup_bits_q) | free_onehot;
				count_q <= count_q - removed_q + CW'(1);
			end
		end
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[free_idx_q] <= s_q;
		if (mem_re)
			rdata_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		rd_vld_s1 <= valid_q[idx_q];
		rd_idx_s1 <= idx_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					s_q          <= set_mask[MW-1:0];
					idx_q        <= '0;
					n_q          <= '0;
					rem_q        <= valid_q;
					sub_found_q  <= 1'b0;
					free_found_q <= 1'b0;
					sup_bits_q   <= '0;
					removed_q    <= '0;
				end
			end
			ST_SCAN: idx_q <= idx_q + IW'(1);
			ST_DUMP_RD: begin
				if (!rem_q[idx_q])
					idx_q <= idx_q + IW'(1);
			end
			ST_DUMP_WR: begin
				if (res_free) begin
					rem_q <= rem_q & ~idx_onehot;
					n_q   <= n_q + NW'(1);
					idx_q <= idx_q + IW'(1);
				end
			end
			default: ;
		endcase
		// compare stage, one slot per cycle in slot order
		if (rd_act_s1) begin
			if (hit_sub)
				sub_found_q <= 1'b1;
			if (hit_sup) begin
				sup_bits_q[rd_idx_s1] <= 1'b1;
				removed_q             <= removed_q + CW'(1);
			end
			if (!free_found_q && (!rd_vld_s1 || hit_sup)) begin
				free_found_q <= 1'b1;
				free_idx_q   <= rd_idx_s1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/minimal_set_absorber_core.sv
// top level of the minimal set absorber: result beat register around the sequencer
// depends on msa_pkg, msa_ctrl and msa_cmp
//
// usage
//   command channel: cmd_valid / cmd_stall carry command and set_mask; a beat is
//   taken when cmd_valid is high and cmd_stall is low. cmd_stall is high from the
//   beat until the last result beat of that command is loaded.
//   result channel: res_valid / res_stall; each result beat is held in an output
//   register until taken. a dump gives one beat per stored set (up to 32), the
//   final one with last set; every other command gives a single beat.
//   timing: add scans each slot once through one shared compare unit, one slot
//   per cycle from the slot memory, then waits for the output register to take
//   its result beat. clear and unknown commands go straight to their result
//   beat. a dump reads each stored set from the slot memory before loading its
//   beat and steps past empty slots; a dump of an empty table gives one beat.
//   a stalled receiver holds the output register; the sequencer waits before
//   loading the next beat and an add only updates the table as its result loads.
//   reset empties the table (valid bits and count cleared, slot memory left as is)
//   and clears both channels.
`default_nettype none

module minimal_set_absorber_core import msa_pkg::*; #(
	parameter int CAPACITY = 32,
	parameter int ELEMENTS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] set_mask,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             accepted,
	output logic [5:0]       removed_count,
	output logic             table_full,
	output logic [5:0]       entry_count,
	output logic             entry_valid,
	output logic [31:0]      entry_mask,
	output logic             last
);

	logic res_valid_q;
	res_t res_q;
	res_t res;
	logic res_load, res_free;

	assign res_free = !res_valid_q || !res_stall;

	msa_ctrl #(.CAPACITY(CAPACITY), .ELEMENTS(ELEMENTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (command),
		.set_mask  (set_mask),
		.cmd_stall (cmd_stall),
		.res_free  (res_free),
		.res_load  (res_load),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (res_load)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load)
			res_q <= res;
	end

	assign res_valid     = res_valid_q;
	assign accepted      = res_q.accepted;
	assign removed_count = res_q.removed_count;
	assign table_full    = res_q.table_full;
	assign entry_count   = res_q.entry_count;
	assign entry_valid   = res_q.entry_valid;
	assign entry_mask    = res_q.entry_mask;
	assign last          = res_q.last;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!res_valid || !res_stall))
		else $error("result loaded over a pending beat");

	a_idle_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_stall |-> !res_load)
		else $error("result loaded while idle");

	a_acc_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(accepted && table_full))
		else $error("add both stored and refused as full");

	a_dump_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && entry_valid) |-> (!accepted && !table_full && removed_count == 6'd0))
		else $error("dump beat carries add status");

endmodule

`default_nettype wire
